@@ hdl/tcsum_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsum_pkg
// Shared types and constants for the TCP over IPv6 checksum block.
// ----------------------------------------------------------------------------
package tcsum_pkg;

   typedef enum logic {
      CMD_ADDR = 1'b0,
      CMD_SEG  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type     command;
      logic [15:0] data_word;
      logic        one_byte;
      logic        last;
   } item_type;

   localparam logic [15:0] NEXT_HEADER_TCP = 16'd6;
   localparam logic [15:0] HIGH_BYTE_MASK  = 16'hff00;

endpackage

@@ hdl/tcsum_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsum_in_reg
// Input register: captures one word per cycle while the pipeline advances.
// ----------------------------------------------------------------------------
module tcsum_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  tcsum_pkg::item_type in_item,
   output logic               out_valid,
   output tcsum_pkg::item_type out_item
);
   import tcsum_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (advance) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ hdl/tcsum_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsum_accum
// Running sum and byte count, end-of-packet fold and result register.
// ----------------------------------------------------------------------------
module tcsum_accum (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  tcsum_pkg::item_type in_item,
   output logic               rsp_valid,
   output logic [15:0]        rsp_checksum,
   output logic [15:0]        rsp_segment_bytes
);
   import tcsum_pkg::*;

   logic [31:0] sum_ff, sum_in;
   logic [15:0] count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] checksum_ff, checksum_in;
   logic [15:0] seg_bytes_ff, seg_bytes_in;

   logic [15:0] addend;
   logic [15:0] count_step;
   logic [31:0] sum_next;
   logic [15:0] count_next;
   logic [31:0] total;
   logic [16:0] fold1;
   logic [15:0] fold2;

   always_comb begin
      addend     = in_item.data_word;
      count_step = 16'd0;
      if (in_item.command == CMD_SEG) begin
         if (in_item.one_byte) begin
            addend     = in_item.data_word & HIGH_BYTE_MASK;
            count_step = 16'd1;
         end else begin
            count_step = 16'd2;
         end
      end
      sum_next   = sum_ff + {16'd0, addend};
      count_next = count_ff + count_step;
      total      = sum_next + {16'd0, count_next} + {16'd0, NEXT_HEADER_TCP};
      fold1      = {1'b0, total[15:0]} + {1'b0, total[31:16]};
      fold2      = fold1[15:0] + {15'd0, fold1[16]};
   end

   always_comb begin
      sum_in       = sum_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      checksum_in  = checksum_ff;
      seg_bytes_in = seg_bytes_ff;
      if (advance) begin
         rsp_valid_in = in_valid & in_item.last;
         if (in_valid) begin
            if (in_item.last) begin
               sum_in       = 32'd0;
               count_in     = 16'd0;
               checksum_in  = ~fold2;
               seg_bytes_in = count_next;
            end else begin
               sum_in   = sum_next;
               count_in = count_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= 32'd0;
         count_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      checksum_ff  <= checksum_in;
      seg_bytes_ff <= seg_bytes_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_checksum      = checksum_ff;
   assign rsp_segment_bytes = seg_bytes_ff;

endmodule

@@ hdl/tcp_ipv6_checksum_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_ipv6_checksum_top
// TCP checksum over an IPv6 pseudo header and a TCP segment.
//
// Send the 16 address words (source, then destination) with req_tuser[0]=0,
// then the segment words with req_tuser[0]=1, first byte in the high half.
// Set req_tuser[1] on a final odd word that holds only its high byte, and
// req_tlast on the last word of the packet. One word is taken per cycle while req_tready is high.
// The segment length is counted from the words, not read from the packet.
// On the last word, one result word (checksum, counted segment length)
// appears on rsp_ after acceptance, behind the input register and the
// result register, and the sum clears itself. Throughput is one word per
// cycle while no result is held back by a low rsp_tready.
// When rsp_tready is low with a result pending, the whole pipeline holds
// and req_tready drops. Reset empties both registers and zeroes the sum.
// ----------------------------------------------------------------------------
module tcp_ipv6_checksum_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] data_word
   input  logic [1:0]  req_tuser,   // [0] command, [1] one_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [15:0] checksum, [31:16] segment_bytes
);
   import tcsum_pkg::*;

   logic     advance;
   item_type req_item;
   logic     s1_valid;
   item_type s1_item;
   logic [15:0] checksum;
   logic [15:0] segment_bytes;

   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   always_comb begin
      req_item.command   = cmd_type'(req_tuser[0]);
      req_item.data_word = req_tdata;
      req_item.one_byte  = req_tuser[1];
      req_item.last      = req_tlast;
   end

   tcsum_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_item   (req_item),
      .out_valid (s1_valid),
      .out_item  (s1_item)
   );

   tcsum_accum u_accum (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .in_valid          (s1_valid),
      .in_item           (s1_item),
      .rsp_valid         (rsp_tvalid),
      .rsp_checksum      (checksum),
      .rsp_segment_bytes (segment_bytes)
   );

   assign rsp_tdata = {segment_bytes, checksum};

endmodule
